// ===== rtl/ftp_reply_code_parser_assert.svh =====
// Assertion macros shared by the reply parser RTL.
// Each macro places one labeled concurrent assertion, disabled while reset is low.
`ifndef FTP_REPLY_CODE_PARSER_ASSERT_SVH
`define FTP_REPLY_CODE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define FRCP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("reply parser assertion failed");

// Next-cycle implication.
`define FRCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("reply parser assertion failed");

`endif

// ===== rtl/frcp_pkg.sv =====
// ----------------------------------------------------------------------------
// frcp_pkg
// Codes, widths and character constants of the FTP reply code parser.
// ----------------------------------------------------------------------------
package frcp_pkg;

    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;
    localparam int CODE_W  = 10;
    localparam int TICKS_W = 20;
    localparam int POS_W   = 3;

    // Event kinds on the input channel.
    localparam logic [MODE_W-1:0] MODE_BYTE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ERROR = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_REPLY   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_TIMEOUT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_CLOSED  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_LOST    = 2'd3;

    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 20'd30000;
    localparam logic [TICKS_W-1:0] IDLE_MAX      = {TICKS_W{1'b1}};

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    // Line positions of interest.
    localparam logic [POS_W-1:0] POS_SEP = 3'd3;
    localparam logic [POS_W-1:0] POS_MAX = 3'd4;

    typedef enum logic [1:0] {
        SEP_SPACE = 2'd0,
        SEP_DASH  = 2'd1,
        SEP_OTHER = 2'd2
    } t_sep;

endpackage

// ===== rtl/ftp_reply_code_parser.sv =====
// ----------------------------------------------------------------------------
// ftp_reply_code_parser
// Parses FTP control-channel bytes and events into reply, timeout, close and
// link-loss results.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------------
//  in       to block   i_in_valid / o_in_stall   i_mode, i_data_byte
//  out      from block o_out_valid / i_out_stall o_status, o_reply_code
//  cfg      to block   i_cfg_wr_en               i_cfg_wr_data (timeout ticks)
//
// One word is taken per cycle unless the input stalls; its result, if any,
// appears in the output register on the next cycle. The parse state, timeout
// and output registers are the only storage; each word's update sets the rate.
// Reset is synchronous; it clears all parse state and sets the timeout register
// to its default of 30000 ticks.
// The input stalls only while a result sits in the output register and the
// output side stalls.
module ftp_reply_code_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [frcp_pkg::MODE_W-1:0]    i_mode,
    input  logic [frcp_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [frcp_pkg::STAT_W-1:0]    o_status,
    output logic [frcp_pkg::CODE_W-1:0]    o_reply_code,
    input  logic                           i_cfg_wr_en,
    input  logic [frcp_pkg::TICKS_W-1:0]   i_cfg_wr_data
);
    import frcp_pkg::*;

    `include "ftp_reply_code_parser_assert.svh"

    logic [TICKS_W-1:0] r_timeout;
    logic [POS_W-1:0]   r_pos,        n_pos;
    logic               r_digits_ok,  n_digits_ok;
    logic [CODE_W-1:0]  r_accum,      n_accum;
    t_sep               r_sep,        n_sep;
    logic               r_multi,      n_multi;
    logic [CODE_W-1:0]  r_open_code,  n_open_code;
    logic [TICKS_W-1:0] r_idle,       n_idle;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status,     n_status;
    logic [CODE_W-1:0]  r_code,       n_code;

    logic               in_acc;
    logic               emit;
    logic               coded;
    logic               is_digit;
    logic [3:0]         digit;
    logic [CODE_W+3:0]  accum_mac;
    logic [TICKS_W-1:0] idle_inc;

    assign o_in_stall   = r_out_valid && i_out_stall;
    assign in_acc       = i_in_valid && !o_in_stall;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_reply_code = r_code;

    assign is_digit  = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
    assign digit     = 4'(i_data_byte - CH_ZERO);
    // Times ten as two shifts and an add.
    assign accum_mac = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) + {10'd0, digit};
    assign idle_inc  = (r_idle == IDLE_MAX) ? r_idle : r_idle + 1'b1;
    assign coded     = (r_pos >= POS_SEP) && r_digits_ok;

    always_comb begin
        n_pos       = r_pos;
        n_digits_ok = r_digits_ok;
        n_accum     = r_accum;
        n_sep       = r_sep;
        n_multi     = r_multi;
        n_open_code = r_open_code;
        n_idle      = r_idle;
        n_status    = STAT_REPLY;
        n_code      = '0;
        emit        = 1'b0;

        if (in_acc) begin
            case (i_mode)
                MODE_CLOSE: begin
                    emit     = 1'b1;
                    n_status = STAT_CLOSED;
                end
                MODE_ERROR: begin
                    emit     = 1'b1;
                    n_status = STAT_LOST;
                end
                MODE_TICK: begin
                    n_idle = idle_inc;
                    if (idle_inc > r_timeout) begin
                        emit     = 1'b1;
                        n_status = STAT_TIMEOUT;
                    end
                end
                default: begin
                    n_idle = '0;
                    if (i_data_byte == CH_LF) begin
                        if (!r_multi) begin
                            if (coded && r_sep == SEP_DASH) begin
                                n_multi     = 1'b1;
                                n_open_code = r_accum;
                            end else if (coded) begin
                                emit   = 1'b1;
                                n_code = r_accum;
                            end
                        end else if (coded && r_sep == SEP_SPACE && r_accum == r_open_code) begin
                            emit   = 1'b1;
                            n_code = r_accum;
                        end
                        n_pos       = '0;
                        n_digits_ok = 1'b1;
                        n_accum     = '0;
                        n_sep       = SEP_SPACE;
                    end else if (i_data_byte != CH_CR) begin
                        if (r_pos < POS_SEP) begin
                            if (is_digit) begin
                                n_accum = accum_mac[CODE_W-1:0];
                            end else begin
                                n_digits_ok = 1'b0;
                            end
                        end else if (r_pos == POS_SEP) begin
                            if (i_data_byte == CH_SPACE) begin
                                n_sep = SEP_SPACE;
                            end else if (i_data_byte == CH_DASH) begin
                                n_sep = SEP_DASH;
                            end else begin
                                n_sep = SEP_OTHER;
                            end
                        end
                        if (r_pos < POS_MAX) begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                end
            endcase

            // Any result returns the whole parse state to reset.
            if (emit) begin
                n_pos       = '0;
                n_digits_ok = 1'b1;
                n_accum     = '0;
                n_sep       = SEP_SPACE;
                n_multi     = 1'b0;
                n_open_code = '0;
                n_idle      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_pos       <= '0;
            r_digits_ok <= 1'b1;
            r_accum     <= '0;
            r_sep       <= SEP_SPACE;
            r_multi     <= 1'b0;
            r_open_code <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            r_pos       <= n_pos;
            r_digits_ok <= n_digits_ok;
            r_accum     <= n_accum;
            r_sep       <= n_sep;
            r_multi     <= n_multi;
            r_open_code <= n_open_code;
            r_idle      <= n_idle;
            if (!o_in_stall) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= n_status;
            r_code   <= n_code;
        end
    end

    `FRCP_ASSERT_IMPL(a_code_zero_unless_reply, i_clk, i_rst_n,
        o_out_valid && (o_status != STAT_REPLY), o_reply_code == '0)
    `FRCP_ASSERT_NEXT(a_close_reports, i_clk, i_rst_n,
        in_acc && (i_mode == MODE_CLOSE), o_out_valid && (o_status == STAT_CLOSED))
    `FRCP_ASSERT_NEXT(a_result_clears_state, i_clk, i_rst_n,
        emit, (r_idle == '0) && !r_multi && (r_pos == '0))
    `FRCP_ASSERT_IMPL(a_multi_needs_no_open_result, i_clk, i_rst_n,
        in_acc && (i_mode == MODE_BYTE) && (i_data_byte != CH_LF), !emit)

endmodule
